FILE: design/ihcc_pkg.sv
// Shared types, constants and the byte-wide CRC step for the image header CRC checker.
package ihcc_pkg;

	// CRC-32 settings: MSB first, no reflection.
	localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_XOR_OUT = 32'hFFFF_FFFF;

	// Header layout and limits.
	localparam logic [31:0] IMAGE_MAGIC     = 32'h00BA_BE00;
	localparam int          MIN_IMAGE_BYTES = 32;

	// Result kinds.
	localparam logic KIND_WORD   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Status codes, in order of priority.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
	localparam logic [1:0] ST_BAD_CRC   = 2'd3;

	// Result queue depth; one byte can cause two results.
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = 2;

	typedef logic [13:0] code_count_t;

	// One result record.
	typedef struct packed {
		logic        run_last;
		code_count_t code_count;
		logic [31:0] locals_words;
		logic [31:0] stack_words;
		logic [1:0]  status;
		logic [31:0] code_word;
		logic        result_kind;
	} ihcc_res_t;

	// Results caused by one accepted byte, first one in res_a.
	typedef struct packed {
		logic [1:0] num;
		ihcc_res_t  res_a;
		ihcc_res_t  res_b;
	} ihcc_push_t;

	// Advance the CRC by one byte, one polynomial step per bit.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] crc;
		crc = crc_in ^ {b, 24'h0};
		for (int k = 0; k < 8; k++) begin
			crc = crc[31] ? ({crc[30:0], 1'b0} ^ CRC_POLY) : {crc[30:0], 1'b0};
		end
		return crc;
	endfunction

endpackage

FILE: design/ihcc_engine.sv
// Per-byte header check, CRC update, code word assembly and status generation.
module ihcc_engine import ihcc_pkg::*; #(
	parameter int MAX_IMAGE_BYTES = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_image,
	output ihcc_push_t push
);

	localparam int CNT_W = $clog2(MAX_IMAGE_BYTES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_IMAGE_BYTES);

	logic [CNT_W-1:0] cnt_q, cnt_n, len;
	logic [31:0]      crc_q, crc_n;
	logic [31:0]      word_q, word_n;
	logic [31:0]      chk_q, chk_n;
	logic [31:0]      stack_q, stack_n;
	logic [31:0]      locals_q, locals_n;
	logic             magic_q, magic_n;
	logic             ovf_q, ovf_n;
	code_count_t      ccnt_q, ccnt_n;
	logic             full_now;
	logic             word_out;
	logic [1:0]       st;
	ihcc_res_t        r_word, r_stat;

	assign full_now = (cnt_q == CNT_MAX);

	// Next state for one byte, before the end-of-image return to reset.
	always_comb begin
		cnt_n    = cnt_q;
		crc_n    = crc_q;
		word_n   = word_q;
		chk_n    = chk_q;
		stack_n  = stack_q;
		locals_n = locals_q;
		magic_n  = magic_q;
		ovf_n    = ovf_q;
		ccnt_n   = ccnt_q;
		word_out = 1'b0;
		if (full_now) begin
			ovf_n = 1'b1;
		end else begin
			word_n = {data_byte, word_q[31:8]};
			if (cnt_q >= CNT_W'(8)) begin
				crc_n = crc_byte(crc_q, data_byte);
			end
			if (cnt_q[1:0] == 2'd3) begin
				priority if (cnt_q == CNT_W'(3)) begin
					if (word_n != IMAGE_MAGIC) begin
						magic_n = 1'b0;
					end
				end else if (cnt_q == CNT_W'(7)) begin
					chk_n = word_n;
				end else if (cnt_q == CNT_W'(11)) begin
					stack_n = word_n;
				end else if (cnt_q == CNT_W'(15)) begin
					locals_n = word_n;
				end else begin
					ccnt_n   = ccnt_q + code_count_t'(1);
					word_out = 1'b1;
				end
			end
			cnt_n = cnt_q + CNT_W'(1);
		end
	end

	// Final status, size first, then magic, then CRC.
	assign len = cnt_n;
	always_comb begin
		priority if (ovf_n || (len < CNT_W'(MIN_IMAGE_BYTES)) || (len[1:0] != 2'd0)) begin
			st = ST_BAD_SIZE;
		end else if (!magic_n) begin
			st = ST_BAD_MAGIC;
		end else if ((crc_n ^ CRC_XOR_OUT) != chk_n) begin
			st = ST_BAD_CRC;
		end else begin
			st = ST_OK;
		end
	end

	// Result records.
	always_comb begin
		r_word.result_kind  = KIND_WORD;
		r_word.code_word    = word_n;
		r_word.status       = ST_OK;
		r_word.stack_words  = stack_n;
		r_word.locals_words = locals_n;
		r_word.code_count   = ccnt_n;
		r_word.run_last     = !end_of_image;

		r_stat.result_kind  = KIND_STATUS;
		r_stat.code_word    = 32'h0;
		r_stat.status       = st;
		r_stat.stack_words  = stack_n;
		r_stat.locals_words = locals_n;
		r_stat.code_count   = ccnt_n;
		r_stat.run_last     = 1'b1;
	end

	// Pack up to two results in order: code word first, status second.
	always_comb begin
		push.res_a = word_out ? r_word : r_stat;
		push.res_b = r_stat;
		push.num   = 2'd0;
		if (accept) begin
			push.num = {1'b0, word_out} + {1'b0, end_of_image};
		end
	end

	// State registers; the last byte of an image returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			crc_q    <= '0;
			word_q   <= '0;
			chk_q    <= '0;
			stack_q  <= '0;
			locals_q <= '0;
			magic_q  <= 1'b1;
			ovf_q    <= 1'b0;
			ccnt_q   <= '0;
		end else if (accept) begin
			if (end_of_image) begin
				cnt_q    <= '0;
				crc_q    <= '0;
				word_q   <= '0;
				chk_q    <= '0;
				stack_q  <= '0;
				locals_q <= '0;
				magic_q  <= 1'b1;
				ovf_q    <= 1'b0;
				ccnt_q   <= '0;
			end else begin
				cnt_q    <= cnt_n;
				crc_q    <= crc_n;
				word_q   <= word_n;
				chk_q    <= chk_n;
				stack_q  <= stack_n;
				locals_q <= locals_n;
				magic_q  <= magic_n;
				ovf_q    <= ovf_n;
				ccnt_q   <= ccnt_n;
			end
		end
	end

endmodule

FILE: design/ihcc_fifo.sv
// Small result queue that takes up to two records per cycle and gives one per cycle while out_ready is high.
module ihcc_fifo import ihcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ihcc_push_t push,
	output logic       room,
	output logic       out_valid,
	input  logic       out_ready,
	output ihcc_res_t  out_res
);

	ihcc_res_t            mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_q, rd_q;
	logic [RES_PTR_W:0]   cnt_q;
	logic                 pop;

	// Room for the worst case of two records from one byte.
	assign room      = (cnt_q <= (RES_PTR_W + 1)'(RES_DEPTH - 2));
	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;

	// Record storage.
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_q] <= push.res_a;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_q + RES_PTR_W'(1)] <= push.res_b;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RES_PTR_W'(push.num);
			rd_q  <= rd_q + RES_PTR_W'(pop);
			cnt_q <= cnt_q + (RES_PTR_W + 1)'(push.num) - (RES_PTR_W + 1)'(pop);
		end
	end

endmodule

FILE: design/image_header_crc_checker_core.sv
// Top level of the image header CRC checker: byte engine and result queue.
//
//   Channel  Dir  Beat contents
//   s_*      in   tdata = data_byte, tlast = end_of_image
//   m_*      out  tdata = code word / status record, tuser = result_kind, tlast = run_last
//
// One byte is taken per cycle while s_tready is high; it updates the header, CRC and word
// state in the same cycle and its results (at most two) enter a four-entry queue.
// Results leave one per cycle while m_tready is high, in the order they entered the queue.
// s_tready drops only while the queue lacks room for two records.
// arst_n clears all but the queue storage; the last byte of an image resets the engine.
module image_header_crc_checker_core import ihcc_pkg::*; #(
	parameter int MAX_IMAGE_BYTES = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] code_word, [33:32] status, [65:34] stack_words,
	// [97:66] locals_words, [111:98] code_count
	output logic [111:0] m_tdata,
	output logic         m_tuser,   // [0] result_kind
	output logic         m_tlast
);

	ihcc_push_t push;
	ihcc_res_t  res;
	logic       room;
	logic       accept;

	assign s_tready = room;
	assign accept   = s_tvalid && room;

	ihcc_engine #(
		.MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (s_tdata),
		.end_of_image(s_tlast),
		.push        (push)
	);

	ihcc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	// Output beat packing.
	assign m_tdata = {res.code_count, res.locals_words, res.stack_words, res.status,
		res.code_word};
	assign m_tuser = res.result_kind;
	assign m_tlast = res.run_last;

endmodule

FILE: tb/sv/ihcc_tb_pkg.sv
// CRC helper shared by the image generator and the result predictor.
package ihcc_tb_pkg;

	import ihcc_pkg::*;

	// Feed one byte into an MSB-first CRC-32, one data bit at a time.
	function automatic logic [31:0] crc32_msb_step(input logic [31:0] acc,
		input logic [7:0] din);
		logic [31:0] r;
		logic        fb;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[31] ^ din[i];
			r = {r[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
		end
		return r;
	endfunction

endpackage

FILE: tb/sv/ihcc_stream_checker.sv
// Watches both streams of the image header CRC checker, predicts each result and compares it.
module ihcc_stream_checker
	import ihcc_pkg::*;
	import ihcc_tb_pkg::*;
#(
	parameter int MAX_BYTES = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,
	input  logic         m_tuser,
	input  logic         m_tlast,
	output int           mismatches,
	output int           queued
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        kind;
		logic [31:0] word;
		logic [1:0]  status;
		logic [31:0] stack;
		logic [31:0] locals;
		code_count_t count;
		logic        last;
	} image_result_t;

	// Results predicted but not yet seen on the output stream, oldest first.
	image_result_t pending_results[$];

	// Predictor state for the image in progress.
	logic [31:0] byte_cnt;
	logic [31:0] crc_acc;
	logic [31:0] word_sr;
	logic [31:0] crc_stored;
	logic [31:0] stack_sz;
	logic [31:0] locals_sz;
	logic        magic_ok;
	logic        over_len;
	logic [31:0] words_seen;

	function automatic void clear_image_state();
		byte_cnt   = '0;
		crc_acc    = '0;
		word_sr    = '0;
		crc_stored = '0;
		stack_sz   = '0;
		locals_sz  = '0;
		magic_ok   = 1'b1;
		over_len   = 1'b0;
		words_seen = '0;
	endfunction

	function automatic void queue_result(input logic kind, input logic [31:0] word,
		input logic [1:0] status, input logic last);
		image_result_t rec;
		rec.kind   = kind;
		rec.word   = word;
		rec.status = status;
		rec.stack  = stack_sz;
		rec.locals = locals_sz;
		rec.count  = words_seen[13:0];
		rec.last   = last;
		pending_results.insert(pending_results.size(), rec);
	endfunction

	// Advance the image state by one byte and queue the results it causes.
	function automatic void take_byte(input logic [7:0] b, input logic fin);
		logic [31:0] pos;
		logic [1:0]  st;
		if (byte_cnt >= MAX_BYTES) begin
			// Bytes past the size limit only mark the image as too long.
			over_len = 1'b1;
		end else begin
			pos = byte_cnt;
			word_sr = {b, word_sr[31:8]};
			if (pos >= 8)
				crc_acc = crc32_msb_step(crc_acc, b);
			if (pos[1:0] == 2'd3) begin
				case (pos)
					3: begin
						if (word_sr != IMAGE_MAGIC)
							magic_ok = 1'b0;
					end
					7: crc_stored = word_sr;
					11: stack_sz = word_sr;
					15: locals_sz = word_sr;
					default: begin
						words_seen++;
						queue_result(KIND_WORD, word_sr, ST_OK, !fin);
					end
				endcase
			end
			byte_cnt = pos + 1;
		end
		if (fin) begin
			// Size beats magic, magic beats CRC.
			if (over_len || byte_cnt < MIN_IMAGE_BYTES || byte_cnt[1:0] != 2'd0)
				st = ST_BAD_SIZE;
			else if (!magic_ok)
				st = ST_BAD_MAGIC;
			else if ((crc_acc ^ CRC_XOR_OUT) != crc_stored)
				st = ST_BAD_CRC;
			else
				st = ST_OK;
			queue_result(KIND_STATUS, 32'h0, st, 1'b1);
			clear_image_state();
		end
	endfunction

	function automatic void flag(input string what, input logic [31:0] want,
		input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
	endfunction

	// Compare one output beat with the oldest prediction.
	function automatic void check_result();
		image_result_t rec;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unpredicted result beat, tdata %h tuser %b", $time,
					m_tdata, m_tuser);
			return;
		end
		rec = pending_results.pop_front();
		if (m_tuser !== rec.kind)
			flag("result_kind", rec.kind, m_tuser);
		if (m_tdata[31:0] !== rec.word)
			flag("code_word", rec.word, m_tdata[31:0]);
		if (m_tdata[33:32] !== rec.status)
			flag("status", rec.status, m_tdata[33:32]);
		if (m_tdata[65:34] !== rec.stack)
			flag("stack_words", rec.stack, m_tdata[65:34]);
		if (m_tdata[97:66] !== rec.locals)
			flag("locals_words", rec.locals, m_tdata[97:66]);
		if (m_tdata[111:98] !== rec.count)
			flag("code_count", rec.count, m_tdata[111:98]);
		if (m_tlast !== rec.last)
			flag("run_last", rec.last, m_tlast);
	endfunction

	// Predict on input beats, compare on output beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_image_state();
			pending_results.delete();
		end else begin
			if (s_tvalid && s_tready)
				take_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				check_result();
		end
		queued = pending_results.size();
	end

endmodule

FILE: tb/sv/tb_image_header_crc_checker_core.sv
// Testbench top for the image header CRC checker: image stimulus, output stalls and verdict.
module tb_image_header_crc_checker_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ihcc_pkg::*;
	import ihcc_tb_pkg::*;

	localparam int MAX_BYTES  = 65536;
	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_BYTES = 1150;

	typedef enum {IMG_GOOD, IMG_BAD_CRC, IMG_BAD_MAGIC, IMG_BAD_BOTH, IMG_NOISE} img_kind_e;
	typedef enum {FILL_RANDOM, FILL_ZEROS, FILL_ONES} img_fill_e;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;   // [7:0] data_byte
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	// [31:0] code_word, [33:32] status, [65:34] stack_words,
	// [97:66] locals_words, [111:98] code_count
	logic [111:0] m_tdata;
	logic         m_tuser;   // [0] result_kind
	logic         m_tlast;

	int mismatches;
	int queued;
	int idle_cycles;
	int sink_hold;
	bit sink_calm;
	bit src_calm;
	int bytes_sent;

	image_header_crc_checker_core #(.MAX_IMAGE_BYTES(MAX_BYTES)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	ihcc_stream_checker #(.MAX_BYTES(MAX_BYTES)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.queued     (queued)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Output side stalls, with calm stretches that toggle at random.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			sink_calm <= ~sink_calm;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_hold <= 0;
		end else if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (!sink_calm && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			sink_hold <= pick_gap();
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles with no beat on either stream.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Offer one byte, wait for its beat, then maybe leave a gap.
	task automatic put_byte(input logic [7:0] b, input logic fin);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
		gap = src_calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Build an image with a valid header (none for noise), then spoil the parts the kind names.
	task automatic send_image(input img_kind_e kind, input int len, input img_fill_e fill);
		logic [7:0]  img[];
		logic [31:0] acc;
		int          k;
		img = new[len];
		for (int i = 0; i < len; i++) begin
			case (fill)
				FILL_ZEROS: img[i] = 8'h00;
				FILL_ONES: img[i] = 8'hFF;
				default: img[i] = 8'($urandom);
			endcase
		end
		if (kind != IMG_NOISE) begin
			for (int i = 0; i < 4 && i < len; i++)
				img[i] = IMAGE_MAGIC[8*i +: 8];
			// Stored CRC covers bytes from 8 up to the size limit.
			acc = '0;
			for (int i = 8; i < len && i < MAX_BYTES; i++)
				acc = crc32_msb_step(acc, img[i]);
			acc = acc ^ CRC_XOR_OUT;
			for (int i = 4; i < 8 && i < len; i++)
				img[i] = acc[8*(i-4) +: 8];
			if ((kind == IMG_BAD_MAGIC || kind == IMG_BAD_BOTH) && len >= 4) begin
				k = $urandom_range(0, 3);
				img[k] = img[k] ^ (8'h01 << $urandom_range(0, 7));
			end
			if ((kind == IMG_BAD_CRC || kind == IMG_BAD_BOTH) && len >= 8) begin
				k = $urandom_range(4, 7);
				img[k] = img[k] ^ (8'h01 << $urandom_range(0, 7));
			end
		end
		for (int i = 0; i < len; i++)
			put_byte(img[i], i == len - 1);
	endtask

	initial begin
		int          r;
		int          len;
		int          start_bytes;
		img_kind_e   kind;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 8'h00;
		s_tlast   <= 1'b0;
		src_calm  = 1'b0;
		bytes_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed images: extremes of content, each status and its priority.
		send_image(IMG_GOOD, 32, FILL_ZEROS);
		send_image(IMG_GOOD, 32, FILL_ONES);
		send_image(IMG_GOOD, 36, FILL_RANDOM);
		send_image(IMG_BAD_CRC, 32, FILL_RANDOM);
		send_image(IMG_BAD_MAGIC, 40, FILL_RANDOM);
		send_image(IMG_BAD_BOTH, 32, FILL_ONES);
		send_image(IMG_GOOD, 31, FILL_RANDOM);
		send_image(IMG_GOOD, 33, FILL_RANDOM);
		send_image(IMG_GOOD, 28, FILL_RANDOM);
		send_image(IMG_BAD_MAGIC, 30, FILL_RANDOM);
		send_image(IMG_NOISE, 1, FILL_ONES);
		send_image(IMG_NOISE, 3, FILL_RANDOM);
		send_image(IMG_NOISE, 32, FILL_RANDOM);

		// Random images, mostly well formed with random content.
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < RANDOM_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				kind = IMG_GOOD;
			else if (r < 62)
				kind = IMG_BAD_CRC;
			else if (r < 72)
				kind = IMG_BAD_MAGIC;
			else if (r < 77)
				kind = IMG_BAD_BOTH;
			else
				kind = IMG_NOISE;
			r = $urandom_range(0, 99);
			if (r < 75)
				len = 4 * $urandom_range(8, 24);
			else if (r < 85)
				len = 4 * $urandom_range(25, 100);
			else
				len = $urandom_range(1, 70);
			src_calm = ($urandom_range(0, 4) == 0);
			send_image(kind, len, FILL_RANDOM);
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		// Drain the outstanding results, then allow for stray beats.
		@(posedge clk);
		while (queued != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && queued == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
